FILE: hdl/vfqe_pkg.sv
`default_nettype none
package vfqe_pkg;

  localparam int COORD_FRAC_BITS_DEF = 16;

  localparam int CFG_W = 25;
  localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(65536);

  localparam logic [0:0] REG_CEILING_HEIGHT = 1'd0;
  localparam logic [0:0] REG_WET_DEPTH      = 1'd1;

  localparam logic [3:0] KIND_NONE        = 4'd0;
  localparam logic [3:0] KIND_WALL        = 4'd1;
  localparam logic [3:0] KIND_FLOOR       = 4'd2;
  localparam logic [3:0] KIND_CEILING     = 4'd3;
  localparam logic [3:0] KIND_RAISED      = 4'd4;
  localparam logic [3:0] KIND_DIAGONAL    = 4'd5;
  localparam logic [3:0] KIND_TRANSPARENT = 4'd6;
  localparam logic [3:0] KIND_EDGE        = 4'd7;
  localparam logic [3:0] KIND_CHASM       = 4'd8;
  localparam logic [3:0] KIND_DOOR        = 4'd9;

  localparam logic [1:0] FACING_POS_X = 2'd0;
  localparam logic [1:0] FACING_NEG_X = 2'd1;
  localparam logic [1:0] FACING_POS_Z = 2'd2;
  localparam logic [1:0] FACING_NEG_Z = 2'd3;

  localparam logic [2:0] FACE_NEAR_X    = 3'd0;
  localparam logic [2:0] FACE_FAR_X     = 3'd1;
  localparam logic [2:0] FACE_NEAR_Y    = 3'd2;
  localparam logic [2:0] FACE_FAR_Y     = 3'd3;
  localparam logic [2:0] FACE_NEAR_Z    = 3'd4;
  localparam logic [2:0] FACE_FAR_Z     = 3'd5;
  localparam logic [2:0] FACE_DIAG_NEAR = 3'd6;
  localparam logic [2:0] FACE_DIAG_FAR  = 3'd7;

  typedef struct packed {
    logic [3:0]         voxel_kind;
    logic signed [15:0] grid_x;
    logic signed [15:0] grid_y;
    logic signed [15:0] grid_z;
    logic               diagonal_first;
    logic [1:0]         facing;
    logic [16:0]        y_offset;
    logic [16:0]        y_size;
    logic               chasm_wet;
    logic [3:0]         chasm_walls;
    logic [5:0]         out_capacity;
  } voxel_t;

  typedef struct packed {
    logic signed [31:0] c0_x;
    logic signed [31:0] c0_y;
    logic signed [31:0] c0_z;
    logic signed [31:0] c1_x;
    logic signed [31:0] c1_y;
    logic signed [31:0] c1_z;
    logic signed [31:0] c2_x;
    logic signed [31:0] c2_y;
    logic signed [31:0] c2_z;
    logic               last_quad;
    logic [2:0]         quad_count;
  } quad_t;

  // Geometry of one voxel, handed from the front pipeline to the emitter.
  typedef struct packed {
    logic [31:0]      ox;
    logic [31:0]      oy;
    logic [31:0]      oz;
    logic [31:0]      yv;
    logic [5:0][2:0]  faces;
    logic [2:0]       n;
    logic             err;
  } geom_t;

  // Corner codes {c2, c1, c0}; bit 0 adds X, bit 1 adds Y, bit 2 adds Z.
  function automatic logic [8:0] face_corners(input logic [2:0] face);
    logic [8:0] r;
    unique case (face)
      FACE_NEAR_X:    r = {3'd6, 3'd4, 3'd0};
      FACE_FAR_X:     r = {3'd3, 3'd1, 3'd5};
      FACE_NEAR_Y:    r = {3'd4, 3'd5, 3'd1};
      FACE_FAR_Y:     r = {3'd7, 3'd6, 3'd2};
      FACE_NEAR_Z:    r = {3'd2, 3'd0, 3'd1};
      FACE_FAR_Z:     r = {3'd7, 3'd5, 3'd4};
      FACE_DIAG_NEAR: r = {3'd7, 3'd5, 3'd0};
      FACE_DIAG_FAR:  r = {3'd6, 3'd4, 3'd1};
      default:        r = '0;
    endcase
    return r;
  endfunction

  function automatic logic [2:0] edge_face(input logic [1:0] facing);
    logic [2:0] r;
    unique case (facing)
      FACING_POS_X: r = FACE_FAR_X;
      FACING_NEG_X: r = FACE_NEAR_X;
      FACING_POS_Z: r = FACE_FAR_Z;
      FACING_NEG_Z: r = FACE_NEAR_Z;
    endcase
    return r;
  endfunction

  function automatic logic [2:0] chasm_wall_face(input logic [1:0] b);
    logic [2:0] r;
    unique case (b)
      2'd0:    r = FACE_NEAR_X;
      2'd1:    r = FACE_FAR_X;
      2'd2:    r = FACE_NEAR_Z;
      default: r = FACE_FAR_Z;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

FILE: hdl/vfqe_geom.sv
`default_nettype none
module vfqe_geom #(
  parameter int COORD_FRAC_BITS = vfqe_pkg::COORD_FRAC_BITS_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic [vfqe_pkg::CFG_W-1:0] ceiling_height,
  input  wire logic [vfqe_pkg::CFG_W-1:0] wet_depth,
  input  wire logic                       voxel_valid,
  output logic                            voxel_ready,
  input  wire vfqe_pkg::voxel_t           voxel,
  output logic                            geom_valid,
  input  wire logic                       geom_ready,
  output vfqe_pkg::geom_t                 geom
);
  import vfqe_pkg::*;

  // Stage 1: face list decode
  logic            v1;
  logic [15:0]     s1_gx, s1_gy, s1_gz;
  logic [16:0]     s1_yoff, s1_ysize;
  logic            s1_raised, s1_edge, s1_chasm, s1_wet, s1_err;
  logic [5:0][2:0] s1_faces;
  logic [2:0]      s1_n;

  // Stage 2: products
  logic            v2;
  logic [31:0]     s2_ox, s2_oz, s2_oy_base, s2_adj, s2_yv;
  logic [5:0][2:0] s2_faces;
  logic [2:0]      s2_n;
  logic            s2_err;

  logic            v3;
  logic            en1, en2, en3;

  logic [5:0][2:0] faces_next;
  logic [2:0]      n_next;
  logic            err_next;

  logic [41:0]     oy_prod;
  logic [41:0]     off_prod;
  logic [41:0]     size_prod;
  logic [CFG_W-1:0] depth;
  logic [31:0]     adj_next;
  logic [31:0]     yv_next;

  assign en3 = !v3 || geom_ready;
  assign en2 = !v2 || en3;
  assign en1 = !v1 || en2;
  assign voxel_ready = en1;
  assign geom_valid = v3;

  always_comb begin
    faces_next = '0;
    n_next = '0;
    unique case (voxel.voxel_kind)
      KIND_WALL, KIND_RAISED: begin
        for (int b = 0; b < 6; b++) begin
          faces_next[b] = 3'(b);
        end
        n_next = 3'd6;
      end
      KIND_FLOOR: begin
        faces_next[0] = FACE_FAR_Y;
        n_next = 3'd1;
      end
      KIND_CEILING: begin
        faces_next[0] = FACE_NEAR_Y;
        n_next = 3'd1;
      end
      KIND_DIAGONAL: begin
        faces_next[0] = voxel.diagonal_first ? FACE_DIAG_NEAR : FACE_DIAG_FAR;
        n_next = 3'd1;
      end
      KIND_TRANSPARENT, KIND_DOOR: begin
        faces_next[0] = FACE_NEAR_X;
        faces_next[1] = FACE_FAR_X;
        faces_next[2] = FACE_NEAR_Z;
        faces_next[3] = FACE_FAR_Z;
        n_next = 3'd4;
      end
      KIND_EDGE: begin
        faces_next[0] = edge_face(voxel.facing);
        n_next = 3'd1;
      end
      KIND_CHASM: begin
        faces_next[0] = FACE_NEAR_Y;
        n_next = 3'd1;
        // pack the visible walls after the floor, in bit order
        for (int b = 0; b < 4; b++) begin
          if (voxel.chasm_walls[b]) begin
            faces_next[n_next] = chasm_wall_face(2'(b));
            n_next = n_next + 3'd1;
          end
        end
      end
      default: begin
        n_next = '0;
      end
    endcase
    err_next = (n_next == 3'd0) || (voxel.out_capacity == 6'd0)
               || (voxel.out_capacity < {3'd0, n_next});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en1) begin
      v1 <= voxel_valid;
    end
    if (en1) begin
      s1_gx     <= voxel.grid_x;
      s1_gy     <= voxel.grid_y;
      s1_gz     <= voxel.grid_z;
      s1_yoff   <= voxel.y_offset;
      s1_ysize  <= voxel.y_size;
      s1_raised <= (voxel.voxel_kind == KIND_RAISED);
      s1_edge   <= (voxel.voxel_kind == KIND_EDGE);
      s1_chasm  <= (voxel.voxel_kind == KIND_CHASM);
      s1_wet    <= voxel.chasm_wet;
      s1_faces  <= faces_next;
      s1_n      <= err_next ? 3'd1 : n_next;
      s1_err    <= err_next;
    end
  end

  assign oy_prod   = 42'($signed(s1_gy) * $signed({1'b0, ceiling_height}));
  assign off_prod  = 42'(s1_yoff) * 42'(ceiling_height);
  assign size_prod = 42'(s1_ysize) * 42'(ceiling_height);
  assign depth     = s1_wet ? wet_depth : ceiling_height;

  always_comb begin
    adj_next = '0;
    yv_next  = 32'(ceiling_height);
    if (s1_chasm) begin
      adj_next = 32'(ceiling_height) - 32'(depth);
      yv_next  = 32'(depth);
    end else if (s1_raised) begin
      adj_next = 32'(off_prod[41:16]);
      yv_next  = 32'(size_prod[41:16]);
    end else if (s1_edge) begin
      adj_next = 32'(off_prod[41:16]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en2) begin
      v2 <= v1;
    end
    if (en2) begin
      s2_ox      <= 32'($signed(s1_gx)) << COORD_FRAC_BITS;
      s2_oz      <= 32'($signed(s1_gz)) << COORD_FRAC_BITS;
      s2_oy_base <= oy_prod[31:0];
      s2_adj     <= adj_next;
      s2_yv      <= yv_next;
      s2_faces   <= s1_faces;
      s2_n       <= s1_n;
      s2_err     <= s1_err;
    end
  end

  // Stage 3: final origin
  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en3) begin
      v3 <= v2;
    end
    if (en3) begin
      geom.ox    <= s2_ox;
      geom.oy    <= s2_oy_base + s2_adj;
      geom.oz    <= s2_oz;
      geom.yv    <= s2_yv;
      geom.faces <= s2_faces;
      geom.n     <= s2_n;
      geom.err   <= s2_err;
    end
  end

endmodule
`default_nettype wire

FILE: hdl/vfqe_emit.sv
`default_nettype none
module vfqe_emit #(
  parameter int COORD_FRAC_BITS = vfqe_pkg::COORD_FRAC_BITS_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              geom_valid,
  output logic                   geom_ready,
  input  wire vfqe_pkg::geom_t   geom,
  output logic                   quad_valid,
  input  wire logic              quad_stall,
  output vfqe_pkg::quad_t        quad
);
  import vfqe_pkg::*;

  localparam logic [31:0] UNIT = 32'(1) << COORD_FRAC_BITS;

  logic        cur_valid;
  geom_t       cur;
  logic [2:0]  k;
  logic        out_load;
  logic        cur_done;
  logic [2:0]  k_last;
  logic [8:0]  codes;
  logic [2:0]  c0, c1, c2;
  quad_t       quad_next;

  assign k_last     = cur.n - 3'd1;
  assign out_load   = cur_valid && (!quad_valid || !quad_stall);
  assign cur_done   = out_load && (k == k_last);
  assign geom_ready = !cur_valid || cur_done;

  assign codes = face_corners(cur.faces[k]);
  assign c0 = codes[2:0];
  assign c1 = codes[5:3];
  assign c2 = codes[8:6];

  always_comb begin
    quad_next = '0;
    quad_next.last_quad = (k == k_last);
    if (!cur.err) begin
      quad_next.c0_x = cur.ox + (c0[0] ? UNIT : 32'd0);
      quad_next.c0_y = cur.oy + (c0[1] ? cur.yv : 32'd0);
      quad_next.c0_z = cur.oz + (c0[2] ? UNIT : 32'd0);
      quad_next.c1_x = cur.ox + (c1[0] ? UNIT : 32'd0);
      quad_next.c1_y = cur.oy + (c1[1] ? cur.yv : 32'd0);
      quad_next.c1_z = cur.oz + (c1[2] ? UNIT : 32'd0);
      quad_next.c2_x = cur.ox + (c2[0] ? UNIT : 32'd0);
      quad_next.c2_y = cur.oy + (c2[1] ? cur.yv : 32'd0);
      quad_next.c2_z = cur.oz + (c2[2] ? UNIT : 32'd0);
      quad_next.quad_count = cur.n;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      k <= '0;
    end else if (geom_ready) begin
      cur_valid <= geom_valid;
      k <= '0;
    end else if (out_load) begin
      k <= k + 3'd1;
    end
    if (geom_ready) begin
      cur <= geom;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      quad_valid <= 1'b0;
    end else if (out_load) begin
      quad_valid <= 1'b1;
    end else if (!quad_stall) begin
      quad_valid <= 1'b0;
    end
    if (out_load) begin
      quad <= quad_next;
    end
  end

endmodule
`default_nettype wire

FILE: hdl/voxel_face_quad_emitter.sv
// Voxel face quad emitter.
// Input channel voxel_valid / voxel_stall / voxel carries one voxel per beat;
// output channel quad_valid / quad_stall / quad carries one face quad per beat
// (three corners, last_quad and quad_count). A voxel gives 1 to 6 quads; an
// empty or unknown kind, or too small out_capacity, gives one quad with count 0.
// The configuration port (cfg_write, cfg_index, cfg_data) sets ceiling_height
// (index 0) and the depth of a wet chasm (index 1); write only while idle.
// Path: the decode register loads at the edge that takes the voxel beat; the
// multiply, origin, emitter and output registers follow in that order, and the
// first quad of a voxel shows on quad_valid from the output register.
// Throughput: one quad per cycle while quad_stall is low; the single result port
// sends a voxel's quads in turn and takes the next voxel as its last quad loads.
// Reset (rst, synchronous) empties every stage and loads 1.0 into both
// registers. When the receiver stalls, the output register holds its quad and
// the pipeline behind it fills, then voxel_stall rises; nothing is lost.
`default_nettype none
module voxel_face_quad_emitter #(
  parameter int COORD_FRAC_BITS = vfqe_pkg::COORD_FRAC_BITS_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       cfg_write,
  input  wire logic [0:0]                 cfg_index,
  input  wire logic [vfqe_pkg::CFG_W-1:0] cfg_data,
  input  wire logic                       voxel_valid,
  output logic                            voxel_stall,
  input  wire vfqe_pkg::voxel_t           voxel,
  output logic                            quad_valid,
  input  wire logic                       quad_stall,
  output vfqe_pkg::quad_t                 quad
);
  import vfqe_pkg::*;

  logic [CFG_W-1:0] ceiling_height;
  logic [CFG_W-1:0] wet_depth;
  logic             voxel_ready;
  logic             geom_valid;
  logic             geom_ready;
  geom_t            geom;

  always_ff @(posedge clk) begin
    if (rst) begin
      ceiling_height <= CFG_RESET;
      wet_depth      <= CFG_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_CEILING_HEIGHT: ceiling_height <= cfg_data;
        REG_WET_DEPTH:      wet_depth      <= cfg_data;
        default: ;
      endcase
    end
  end

  assign voxel_stall = !voxel_ready;

  vfqe_geom #(
    .COORD_FRAC_BITS(COORD_FRAC_BITS)
  ) u_geom (
    .clk            (clk),
    .rst            (rst),
    .ceiling_height (ceiling_height),
    .wet_depth      (wet_depth),
    .voxel_valid    (voxel_valid),
    .voxel_ready    (voxel_ready),
    .voxel          (voxel),
    .geom_valid     (geom_valid),
    .geom_ready     (geom_ready),
    .geom           (geom)
  );

  vfqe_emit #(
    .COORD_FRAC_BITS(COORD_FRAC_BITS)
  ) u_emit (
    .clk        (clk),
    .rst        (rst),
    .geom_valid (geom_valid),
    .geom_ready (geom_ready),
    .geom       (geom),
    .quad_valid (quad_valid),
    .quad_stall (quad_stall),
    .quad       (quad)
  );

endmodule
`default_nettype wire

FILE: test/testbench.sv
`default_nettype none
module testbench;
  import vfqe_pkg::*;

  localparam int LIMIT = 400000;
  localparam logic [31:0] UNIT = 32'h0001_0000;
  localparam logic [CFG_W-1:0] MAX_HEIGHT = CFG_W'(25'h100_0000);
  localparam logic [3:0] KIND_UNKNOWN_TOP = 4'd15;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_write = 1'b0;
  logic [0:0] cfg_index = REG_CEILING_HEIGHT;
  logic [CFG_W-1:0] cfg_data = '0;
  logic voxel_valid = 1'b0;
  logic voxel_stall;
  voxel_t voxel = '0;
  logic quad_valid;
  logic quad_stall = 1'b0;
  quad_t quad;

  // Shadow copies of the height registers.
  logic [CFG_W-1:0] ceil_h = CFG_RESET;
  logic [CFG_W-1:0] wet_depth = CFG_RESET;

  quad_t expected_quads[$];
  quad_t want;
  int bad_quads = 0;
  int reported = 0;
  int cycle_count = 0;
  int src_idle_pct = 0;
  int sink_stall_pct = 0;

  voxel_face_quad_emitter uut (
    .clk(clk),
    .rst(rst),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .voxel_valid(voxel_valid),
    .voxel_stall(voxel_stall),
    .voxel(voxel),
    .quad_valid(quad_valid),
    .quad_stall(quad_stall),
    .quad(quad)
  );

  always #1 clk = ~clk;

  // Corner codes {c0, c1, c2}: bit 0 steps X, bit 1 steps Y, bit 2 steps Z.
  function automatic logic [0:2][2:0] face_codes(input logic [2:0] face);
    case (face)
      FACE_NEAR_X:    return {3'd0, 3'd4, 3'd6};
      FACE_FAR_X:     return {3'd5, 3'd1, 3'd3};
      FACE_NEAR_Y:    return {3'd1, 3'd5, 3'd4};
      FACE_FAR_Y:     return {3'd2, 3'd6, 3'd7};
      FACE_NEAR_Z:    return {3'd1, 3'd0, 3'd2};
      FACE_FAR_Z:     return {3'd4, 3'd5, 3'd7};
      FACE_DIAG_NEAR: return {3'd0, 3'd5, 3'd7};
      FACE_DIAG_FAR:  return {3'd1, 3'd4, 3'd6};
      default:        return '0;
    endcase
  endfunction

  function automatic void predict_quads(input voxel_t v);
    logic [63:0] gy64;
    logic [63:0] yoff_h;
    logic [63:0] ysize_h;
    logic [31:0] ox, oy, oz, yv, depth;
    logic [5:0][2:0] faces;
    logic [0:2][2:0] codes;
    logic [0:2][31:0] px, py, pz;
    int n;
    quad_t q;
    gy64 = {{48{v.grid_y[15]}}, v.grid_y};
    ox = {v.grid_x, 16'h0000};
    oz = {v.grid_z, 16'h0000};
    oy = 32'(gy64 * {39'd0, ceil_h});
    yv = {7'd0, ceil_h};
    yoff_h = ({47'd0, v.y_offset} * {39'd0, ceil_h}) >> 16;
    ysize_h = ({47'd0, v.y_size} * {39'd0, ceil_h}) >> 16;
    faces = '0;
    n = 0;
    case (v.voxel_kind)
      KIND_WALL, KIND_RAISED: begin
        faces = {FACE_FAR_Z, FACE_NEAR_Z, FACE_FAR_Y, FACE_NEAR_Y, FACE_FAR_X, FACE_NEAR_X};
        n = 6;
        if (v.voxel_kind == KIND_RAISED) begin
          oy = oy + yoff_h[31:0];
          yv = ysize_h[31:0];
        end
      end
      KIND_FLOOR: begin
        faces[0] = FACE_FAR_Y;
        n = 1;
      end
      KIND_CEILING: begin
        faces[0] = FACE_NEAR_Y;
        n = 1;
      end
      KIND_DIAGONAL: begin
        faces[0] = v.diagonal_first ? FACE_DIAG_NEAR : FACE_DIAG_FAR;
        n = 1;
      end
      KIND_TRANSPARENT, KIND_DOOR: begin
        faces[3:0] = {FACE_FAR_Z, FACE_NEAR_Z, FACE_FAR_X, FACE_NEAR_X};
        n = 4;
      end
      KIND_EDGE: begin
        oy = oy + yoff_h[31:0];
        case (v.facing)
          FACING_POS_X: faces[0] = FACE_FAR_X;
          FACING_NEG_X: faces[0] = FACE_NEAR_X;
          FACING_POS_Z: faces[0] = FACE_FAR_Z;
          default:      faces[0] = FACE_NEAR_Z;
        endcase
        n = 1;
      end
      KIND_CHASM: begin
        depth = v.chasm_wet ? {7'd0, wet_depth} : {7'd0, ceil_h};
        oy = oy + {7'd0, ceil_h} - depth;
        yv = depth;
        faces[0] = FACE_NEAR_Y;
        n = 1;
        // wall bits in order: near X, far X, near Z, far Z
        if (v.chasm_walls[0]) begin
          faces[n] = FACE_NEAR_X;
          n++;
        end
        if (v.chasm_walls[1]) begin
          faces[n] = FACE_FAR_X;
          n++;
        end
        if (v.chasm_walls[2]) begin
          faces[n] = FACE_NEAR_Z;
          n++;
        end
        if (v.chasm_walls[3]) begin
          faces[n] = FACE_FAR_Z;
          n++;
        end
      end
      default: n = 0;
    endcase

    // Nothing to draw or no room for it: one empty quad.
    if (n == 0 || v.out_capacity == 0 || v.out_capacity < n) begin
      q = '0;
      q.last_quad = 1'b1;
      expected_quads.push_back(q);
      return;
    end
    for (int k = 0; k < n; k++) begin
      codes = face_codes(faces[k]);
      for (int c = 0; c < 3; c++) begin
        px[c] = ox + (codes[c][0] ? UNIT : 32'd0);
        py[c] = oy + (codes[c][1] ? yv : 32'd0);
        pz[c] = oz + (codes[c][2] ? UNIT : 32'd0);
      end
      q.c0_x = px[0];
      q.c0_y = py[0];
      q.c0_z = pz[0];
      q.c1_x = px[1];
      q.c1_y = py[1];
      q.c1_z = pz[1];
      q.c2_x = px[2];
      q.c2_y = py[2];
      q.c2_z = pz[2];
      q.last_quad = (k == n - 1);
      q.quad_count = 3'(n);
      expected_quads.push_back(q);
    end
  endfunction

  function automatic logic [15:0] pick_coord();
    int r;
    r = $urandom_range(9);
    if (r < 6) return 16'($urandom_range(128) - 64);
    else if (r < 9) return 16'($urandom);
    else return $urandom_range(1) ? 16'h7fff : 16'h8000;
  endfunction

  function automatic logic [16:0] pick_frac();
    int r;
    r = $urandom_range(19);
    if (r == 0) return '0;
    else if (r < 3) return 17'h1_0000;
    else if (r == 3) return 17'($urandom_range(65537, 131071));
    else return 17'($urandom_range(65535));
  endfunction

  function automatic logic [CFG_W-1:0] random_height(input logic allow_zero);
    case ($urandom_range(3))
      0:       return allow_zero ? '0 : CFG_W'(1);
      1:       return MAX_HEIGHT;
      2:       return CFG_RESET;
      default: return CFG_W'($urandom_range(1, 1 << 24));
    endcase
  endfunction

  function automatic voxel_t random_voxel();
    voxel_t v;
    int r;
    r = $urandom_range(99);
    if (r < 86) v.voxel_kind = 4'($urandom_range(KIND_WALL, KIND_DOOR));
    else if (r < 93) v.voxel_kind = KIND_NONE;
    else v.voxel_kind = 4'($urandom_range(KIND_DOOR + 1, KIND_UNKNOWN_TOP));
    v.grid_x = pick_coord();
    v.grid_y = pick_coord();
    v.grid_z = pick_coord();
    v.diagonal_first = 1'($urandom_range(1));
    v.facing = 2'($urandom_range(3));
    v.y_offset = pick_frac();
    v.y_size = pick_frac();
    v.chasm_wet = 1'($urandom_range(1));
    v.chasm_walls = 4'($urandom_range(15));
    r = $urandom_range(99);
    if (r < 80) v.out_capacity = 6'($urandom_range(6, 63));
    else if (r < 92) v.out_capacity = 6'($urandom_range(1, 5));
    else v.out_capacity = '0;
    return v;
  endfunction

  task automatic send_voxel(input voxel_t v);
    while ($urandom_range(99) < src_idle_pct) begin
      voxel_valid <= 1'b0;
      @(posedge clk);
    end
    voxel <= v;
    voxel_valid <= 1'b1;
    @(posedge clk);
    while (voxel_stall) @(posedge clk);
    predict_quads(v);
  endtask

  // Hold off the input until every expected quad is out, then let the pipe settle.
  task automatic drain_quads();
    voxel_valid <= 1'b0;
    while (expected_quads.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_heights(input logic [CFG_W-1:0] ceil, input logic [CFG_W-1:0] wet);
    cfg_write <= 1'b1;
    cfg_index <= REG_CEILING_HEIGHT;
    cfg_data <= ceil;
    @(posedge clk);
    cfg_index <= REG_WET_DEPTH;
    cfg_data <= wet;
    @(posedge clk);
    cfg_write <= 1'b0;
    ceil_h = ceil;
    wet_depth = wet;
  endtask

  task automatic test_each_kind();
    voxel_t v;
    logic [3:0] kinds [10];
    logic [1:0] facings [3];
    kinds = '{KIND_NONE, KIND_WALL, KIND_FLOOR, KIND_CEILING, KIND_RAISED,
              KIND_DIAGONAL, KIND_TRANSPARENT, KIND_EDGE, KIND_CHASM, KIND_DOOR};
    facings = '{FACING_NEG_X, FACING_POS_Z, FACING_NEG_Z};
    v = '0;
    v.out_capacity = 6'd63;
    v.y_offset = 17'd16384;
    v.y_size = 17'd32768;
    v.chasm_walls = 4'hf;
    for (int k = 0; k < 10; k++) begin
      v.voxel_kind = kinds[k];
      v.grid_x = k[0] ? 16'h7fff : 16'h8000;
      v.grid_y = k[1] ? 16'h7fff : 16'h8000;
      v.grid_z = k[2] ? 16'h0000 : 16'hffff;
      v.diagonal_first = k[0];
      v.chasm_wet = k[0];
      send_voxel(v);
    end
    v.voxel_kind = KIND_UNKNOWN_TOP;
    send_voxel(v);
    v.voxel_kind = KIND_DIAGONAL;
    v.diagonal_first = 1'b0;
    send_voxel(v);
    v.voxel_kind = KIND_EDGE;
    v.y_offset = 17'h1_0000;
    for (int k = 0; k < 3; k++) begin
      v.facing = facings[k];
      send_voxel(v);
    end
    v.voxel_kind = KIND_CHASM;
    v.chasm_wet = 1'b1;
    v.chasm_walls = 4'b0101;
    send_voxel(v);
  endtask

  task automatic test_capacity();
    voxel_t v;
    v = '0;
    v.voxel_kind = KIND_WALL;
    v.grid_x = 16'd3;
    v.grid_z = 16'hfffd;
    v.out_capacity = 6'd0;
    send_voxel(v);
    v.out_capacity = 6'd5;
    send_voxel(v);
    v.out_capacity = 6'd6;
    send_voxel(v);
    v.voxel_kind = KIND_CHASM;
    v.chasm_walls = 4'hf;
    v.chasm_wet = 1'b1;
    v.out_capacity = 6'd4;
    send_voxel(v);
    v.out_capacity = 6'd5;
    send_voxel(v);
  endtask

  task automatic test_height_extremes();
    voxel_t v;
    v = '0;
    v.out_capacity = 6'd63;
    v.chasm_walls = 4'hf;
    drain_quads();
    set_heights(CFG_W'(1), '0);
    for (int pass = 0; pass < 2; pass++) begin
      v.grid_y = pass[0] ? 16'h7fff : 16'hfff0;
      v.voxel_kind = KIND_RAISED;
      v.y_offset = 17'h1_0000;
      v.y_size = 17'h1_0000;
      send_voxel(v);
      v.voxel_kind = KIND_CHASM;
      v.chasm_wet = 1'b1;
      send_voxel(v);
      v.voxel_kind = KIND_EDGE;
      v.y_offset = 17'h1_ffff;
      send_voxel(v);
      if (pass == 0) begin
        drain_quads();
        set_heights(MAX_HEIGHT, MAX_HEIGHT);
      end
    end
  endtask

  task automatic test_random_traffic();
    for (int phase = 0; phase < 3; phase++) begin
      drain_quads();
      set_heights(random_height(1'b0), random_height(1'b1));
      case (phase)
        0: begin
          src_idle_pct = 21;
          sink_stall_pct = 84;
        end
        1: begin
          src_idle_pct = 84;
          sink_stall_pct = 21;
        end
        default: begin
          src_idle_pct = 0;
          sink_stall_pct = 0;
        end
      endcase
      for (int i = 0; i < 28; i++) send_voxel(random_voxel());
    end
    drain_quads();
  endtask

  always @(posedge clk) begin
    quad_stall <= !rst && ($urandom_range(99) < sink_stall_pct);
  end

  always @(posedge clk) begin
    if (!rst && quad_valid && !quad_stall) begin
      if (expected_quads.size() == 0) begin
        bad_quads++;
        if (reported < 10) begin
          reported++;
          $display("unexpected quad beat: %h", quad);
        end
      end else begin
        want = expected_quads.pop_front();
        if (quad.c0_x !== want.c0_x || quad.c0_y !== want.c0_y || quad.c0_z !== want.c0_z ||
            quad.c1_x !== want.c1_x || quad.c1_y !== want.c1_y || quad.c1_z !== want.c1_z ||
            quad.c2_x !== want.c2_x || quad.c2_y !== want.c2_y || quad.c2_z !== want.c2_z ||
            quad.last_quad !== want.last_quad || quad.quad_count !== want.quad_count) begin
          bad_quads++;
          if (reported < 10) begin
            reported++;
            $display("quad mismatch expected: %h %h %h | %h %h %h | %h %h %h last=%b n=%0d",
                     want.c0_x, want.c0_y, want.c0_z, want.c1_x, want.c1_y, want.c1_z,
                     want.c2_x, want.c2_y, want.c2_z, want.last_quad, want.quad_count);
            $display("quad mismatch actual:   %h %h %h | %h %h %h | %h %h %h last=%b n=%0d",
                     quad.c0_x, quad.c0_y, quad.c0_z, quad.c1_x, quad.c1_y, quad.c1_z,
                     quad.c2_x, quad.c2_y, quad.c2_z, quad.last_quad, quad.quad_count);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  initial begin
    src_idle_pct = 21;
    sink_stall_pct = 84;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    test_each_kind();
    test_capacity();
    test_height_extremes();
    test_random_traffic();
    if (bad_quads == 0 && expected_quads.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
`default_nettype wire
